/* rtl/core/asp_pkg.sv */
package asp_pkg;

	typedef enum logic [1:0] {
		CLS_ZERO  = 2'd0,
		CLS_FULL  = 2'd1,
		CLS_LIN   = 2'd2,
		CLS_CURVE = 2'd3
	} cls_t;

	localparam logic REG_STRENGTH = 1'b0;
	localparam logic REG_BLACK    = 1'b1;

	localparam int BETA_W = 24;
	localparam int OFF_W  = 16;
	localparam int PIX_W  = 17;
	localparam int P_W    = 16;
	localparam int EW     = 5;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

endpackage

/* rtl/core/asp_fifo.sv */
module asp_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [asp_pkg::QDEPTH];
	logic [asp_pkg::QAW-1:0] wr_q, rd_q;
	logic [asp_pkg::QAW:0] cnt_q;
	logic do_push, do_pop;

	assign full     = cnt_q == (asp_pkg::QAW+1)'(asp_pkg::QDEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end
endmodule

/* rtl/core/asp_front.sv */
module asp_front #(
	parameter int FRAC_BITS = 16,
	localparam int YW = FRAC_BITS + 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [23:0]          beta,
	input  logic [15:0]          offset,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [16:0]          pixel,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_full,
	output logic [YW-1:0]        y_a,
	output logic [YW-1:0]        y_b,
	output logic [15:0]          p,
	output logic                 out_last,
	output asp_pkg::cls_t        out_cls
);
	localparam int NS = 17;
	localparam int SH = 24 - FRAC_BITS;
	localparam int SB = FRAC_BITS - 8;

	logic en;
	logic          vld_s  [NS+1];
	asp_pkg::cls_t cls_s  [NS+1];
	logic          last_s [NS+1];
	logic [23:0]   beta_s [NS];
	logic [16:0]   d_s    [NS];
	logic [16:0]   rem_s  [NS];
	logic [15:0]   quo_s  [NS];
	logic [YW-1:0] ya_s, yb_s;
	logic [15:0]   p_s;

	logic [16:0]   diff_c;
	asp_pkg::cls_t cls_c;
	logic [17:0]   t_c  [NS];
	logic          ge_c [NS];
	logic [39:0]   prod_c;

	assign en        = !(vld_s[NS] && out_full);
	assign in_ready  = en;
	assign out_valid = vld_s[NS];
	assign y_a       = ya_s;
	assign y_b       = yb_s;
	assign p         = p_s;
	assign out_last  = last_s[NS];
	assign out_cls   = cls_s[NS];

	always_comb begin
		diff_c = pixel - {1'b0, offset};
		if (pixel <= {1'b0, offset})
			cls_c = asp_pkg::CLS_ZERO;
		else if (pixel[16])
			cls_c = asp_pkg::CLS_FULL;
		else if (beta == '0)
			cls_c = asp_pkg::CLS_LIN;
		else
			cls_c = asp_pkg::CLS_CURVE;
	end

	always_comb begin
		t_c[0]  = '0;
		ge_c[0] = 1'b0;
		for (int k = 1; k < NS; k++) begin
			t_c[k]  = {rem_s[k-1], 1'b0};
			ge_c[k] = t_c[k] >= {1'b0, d_s[k-1]};
		end
		prod_c = 40'(beta_s[NS-1]) * 40'(quo_s[NS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= NS; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s[0]  <= cls_c;
			last_s[0] <= last;
			beta_s[0] <= beta;
			d_s[0]    <= 17'h10000 - {1'b0, offset};
			rem_s[0]  <= diff_c;
			quo_s[0]  <= '0;
			for (int k = 1; k < NS; k++) begin
				beta_s[k] <= beta_s[k-1];
				d_s[k]    <= d_s[k-1];
				rem_s[k]  <= ge_c[k] ? 17'(t_c[k] - {1'b0, d_s[k-1]}) : t_c[k][16:0];
				quo_s[k]  <= {quo_s[k-1][14:0], ge_c[k]};
			end
			for (int k = 1; k <= NS; k++) begin
				cls_s[k]  <= cls_s[k-1];
				last_s[k] <= last_s[k-1];
			end
			ya_s <= prod_c[39:SH];
			yb_s <= YW'(beta_s[NS-1]) << SB;
			p_s  <= quo_s[NS-1];
		end
	end
endmodule

/* rtl/core/asp_ln.sv */
module asp_ln #(
	parameter int FRAC_BITS = 16,
	parameter int TW = 1,
	localparam int LW = FRAC_BITS + 16,
	localparam int OW = asp_pkg::EW + FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [LW-1:0] v,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [OW-1:0] res,
	output logic [TW-1:0] tag_out
);
	localparam int F  = FRAC_BITS;
	localparam int EW = asp_pkg::EW;
	localparam int NS = F + 3;
	localparam int PW = OW + 32;

	logic          vld_s  [NS+1];
	logic [TW-1:0] tag_s  [NS+1];
	logic [EW-1:0] e_s    [F+2];
	logic [LW-1:0] v_s0;
	logic [F:0]    m_s    [F+2];
	logic [F-1:0]  frac_s [F+2];
	logic [PW-1:0] prod_s;
	logic [OW-1:0] res_s;

	logic [EW-1:0]  e_c;
	logic [2*F+1:0] sq_c  [F+2];
	logic [F+1:0]   m2_c  [F+2];

	assign out_valid = vld_s[NS];
	assign tag_out   = tag_s[NS];
	assign res       = res_s;

	always_comb begin
		e_c = '0;
		for (int i = F + 1; i < LW; i++)
			if (v[i])
				e_c = EW'(i - F);
		sq_c[0] = '0;
		sq_c[1] = '0;
		m2_c[0] = '0;
		m2_c[1] = '0;
		for (int k = 2; k <= F + 1; k++) begin
			sq_c[k] = (2*F+2)'(m_s[k-1]) * (2*F+2)'(m_s[k-1]);
			m2_c[k] = sq_c[k][2*F+1:F];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= NS; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int k = 1; k <= NS; k++)
				tag_s[k] <= tag_s[k-1];
			e_s[0] <= e_c;
			v_s0   <= v;
			for (int k = 1; k <= F + 1; k++)
				e_s[k] <= e_s[k-1];
			m_s[0]    <= '0;
			frac_s[0] <= '0;
			m_s[1]    <= (F+1)'(v_s0 >> e_s[0]);
			frac_s[1] <= '0;
			for (int k = 2; k <= F + 1; k++) begin
				m_s[k]    <= m2_c[k][F+1] ? m2_c[k][F+1:1] : m2_c[k][F:0];
				frac_s[k] <= {frac_s[k-1][F-2:0], m2_c[k][F+1]};
			end
			prod_s <= PW'({e_s[F+1], frac_s[F+1]}) * PW'(asp_pkg::LN2_Q32);
			res_s  <= OW'((prod_s + PW'(64'h8000_0000)) >> 32);
		end
	end
endmodule

/* rtl/core/asp_asinh.sv */
module asp_asinh #(
	parameter int FRAC_BITS = 16,
	parameter int TW = 1,
	localparam int YW = FRAC_BITS + 16,
	localparam int AW = asp_pkg::EW + FRAC_BITS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [YW-1:0] y,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [AW-1:0] res,
	output logic [TW-1:0] tag_out
);
	localparam int F   = FRAC_BITS;
	localparam int DS  = F + 1;
	localparam int SW  = 2 * F + 2;
	localparam int LA  = DS + F + 4;
	localparam int LNW = AW - 1;
	localparam logic [YW-1:0] ONE_Y  = YW'(1) << F;
	localparam logic [YW-1:0] HALF_Y = YW'(1) << (F - 1);
	localparam logic [SW-1:0] ONE_S  = SW'(1) << F;
	localparam logic [SW-1:0] ONE2_S = SW'(1) << (2 * F);

	logic          vld_s [LA];
	logic [TW-1:0] tag_s [LA];
	logic [YW-1:0] y_s   [LA];
	logic          lt_s  [LA];
	logic [YW-1:0] rem_s [DS+1];
	logic [F:0]    r_s   [DS+1];
	logic [SW-1:0] sq_s;
	logic [SW-1:0] sarg_s [F+2];
	logic [F+2:0]  srem_s [F+2];
	logic [F:0]    root_s [F+2];
	logic          vld_la;
	logic [TW-1:0] tag_la;
	logic [YW-1:0] a1_la, a2_la;
	logic          vld_q;
	logic [AW-1:0] res_q;
	logic [TW-1:0] tag_q;

	logic [YW:0]   t_c    [DS+1];
	logic          ge_c   [DS+1];
	logic [F:0]    sqop_c;
	logic [F+4:0]  remn_c [F+2];
	logic [F+2:0]  trial_c[F+2];
	logic          sge_c  [F+2];

	logic           l1_v;
	logic [LNW-1:0] l1_r, l2_r;
	logic [TW-1:0]  l1_t;

	assign out_valid = vld_q;
	assign res       = res_q;
	assign tag_out   = tag_q;

	always_comb begin
		t_c[0]  = '0;
		ge_c[0] = 1'b0;
		for (int k = 1; k <= DS; k++) begin
			t_c[k]  = {rem_s[k-1], 1'b0};
			ge_c[k] = t_c[k] >= {1'b0, y_s[k-1]};
		end
		sqop_c = lt_s[DS] ? (F+1)'(y_s[DS][F-1:0]) : r_s[DS];
		remn_c[0]  = '0;
		trial_c[0] = '0;
		sge_c[0]   = 1'b0;
		for (int j = 1; j <= F + 1; j++) begin
			remn_c[j]  = {srem_s[j-1], sarg_s[j-1][SW-1 -: 2]};
			trial_c[j] = {root_s[j-1], 2'b01};
			sge_c[j]   = remn_c[j] >= (F+5)'(trial_c[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LA; k++)
				vld_s[k] <= 1'b0;
			vld_la <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LA; k++)
				vld_s[k] <= vld_s[k-1];
			vld_la <= vld_s[LA-1];
			vld_q  <= l1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			y_s[0]   <= y;
			lt_s[0]  <= y < ONE_Y;
			for (int k = 1; k < LA; k++) begin
				tag_s[k] <= tag_s[k-1];
				y_s[k]   <= y_s[k-1];
				lt_s[k]  <= lt_s[k-1];
			end
			rem_s[0] <= HALF_Y;
			r_s[0]   <= '0;
			for (int k = 1; k <= DS; k++) begin
				rem_s[k] <= ge_c[k] ? YW'(t_c[k] - {1'b0, y_s[k-1]}) : t_c[k][YW-1:0];
				r_s[k]   <= {r_s[k-1][F-1:0], ge_c[k]};
			end
			sq_s <= SW'(sqop_c) * SW'(sqop_c);
			sarg_s[0] <= lt_s[DS+1] ? ONE2_S + sq_s : SW'((ONE_S + (sq_s >> F)) << F);
			srem_s[0] <= '0;
			root_s[0] <= '0;
			for (int j = 1; j <= F + 1; j++) begin
				sarg_s[j] <= sarg_s[j-1] << 2;
				srem_s[j] <= sge_c[j] ? (F+3)'(remn_c[j] - (F+5)'(trial_c[j]))
					: (F+3)'(remn_c[j]);
				root_s[j] <= {root_s[j-1][F-1:0], sge_c[j]};
			end
			tag_la <= tag_s[LA-1];
			a1_la  <= lt_s[LA-1] ? y_s[LA-1] + YW'(root_s[F+1]) : y_s[LA-1];
			a2_la  <= lt_s[LA-1] ? ONE_Y : ONE_Y + YW'(root_s[F+1]);
			res_q  <= AW'(l1_r) + AW'(l2_r);
			tag_q  <= l1_t;
		end
	end

	asp_ln #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_ln_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_la), .v(a1_la), .tag_in(tag_la),
		.out_valid(l1_v), .res(l1_r), .tag_out(l1_t)
	);

	asp_ln #(.FRAC_BITS(FRAC_BITS), .TW(1)) u_ln_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_la), .v(a2_la), .tag_in(1'b0),
		.out_valid(), .res(l2_r), .tag_out()
	);
endmodule

/* rtl/core/asp_back.sv */
module asp_back #(
	parameter int FRAC_BITS = 16,
	localparam int YW = FRAC_BITS + 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          pop,
	input  logic [YW-1:0] y_a,
	input  logic [YW-1:0] y_b,
	input  logic [15:0]   p,
	input  logic          last,
	input  asp_pkg::cls_t cls,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [16:0]   pixel,
	output logic          out_last
);
	localparam int AW = asp_pkg::EW + FRAC_BITS + 1;
	localparam int NW = AW + 17;
	localparam int DS = 17;
	localparam int TW = 19;

	logic en;
	logic          av, bv_unused;
	logic [AW-1:0] a_r, b_r;
	logic [TW-1:0] a_t;
	logic [15:0]   tp;
	logic          tl;
	asp_pkg::cls_t tc;
	logic [NW-1:0] n_c;
	logic [16:0]   fix_c;
	logic          useq_c;

	logic          vld_s  [DS+1];
	logic          last_s [DS+1];
	logic          useq_s [DS+1];
	logic [16:0]   fix_s  [DS+1];
	logic [AW-1:0] b_s    [DS+1];
	logic [AW-1:0] rem_s  [DS+1];
	logic [16:0]   nlo_s  [DS+1];
	logic [16:0]   q_s    [DS+1];
	logic [AW:0]   t_c    [DS+1];
	logic          ge_c   [DS+1];

	logic          ov_q;
	logic [16:0]   pix_q;
	logic          last_q;

	assign en        = !(ov_q && !out_ready);
	assign pop       = en;
	assign out_valid = ov_q;
	assign pixel     = pix_q;
	assign out_last  = last_q;
	assign {tp, tl}  = a_t[TW-1:2];
	assign tc        = asp_pkg::cls_t'(a_t[1:0]);

	asp_asinh #(.FRAC_BITS(FRAC_BITS), .TW(TW)) u_asinh_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .y(y_a), .tag_in({p, last, cls}),
		.out_valid(av), .res(a_r), .tag_out(a_t)
	);

	asp_asinh #(.FRAC_BITS(FRAC_BITS), .TW(1)) u_asinh_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .y(y_b), .tag_in(1'b0),
		.out_valid(bv_unused), .res(b_r), .tag_out()
	);

	always_comb begin
		n_c    = NW'({a_r, 16'b0}) + NW'(b_r >> 1);
		useq_c = 1'b0;
		case (tc)
			asp_pkg::CLS_ZERO: fix_c = '0;
			asp_pkg::CLS_FULL: fix_c = 17'h10000;
			asp_pkg::CLS_LIN:  fix_c = {1'b0, tp};
			asp_pkg::CLS_CURVE: begin
				if (b_r == '0)
					fix_c = {1'b0, tp};
				else if (a_r > b_r)
					fix_c = 17'h10000;
				else begin
					fix_c  = '0;
					useq_c = 1'b1;
				end
			end
			default: fix_c = '0;
		endcase
		t_c[0]  = '0;
		ge_c[0] = 1'b0;
		for (int k = 1; k <= DS; k++) begin
			t_c[k]  = {rem_s[k-1], nlo_s[k-1][16]};
			ge_c[k] = t_c[k] >= {1'b0, b_s[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DS; k++)
				vld_s[k] <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= av;
			for (int k = 1; k <= DS; k++)
				vld_s[k] <= vld_s[k-1];
			ov_q <= vld_s[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s[0] <= tl;
			useq_s[0] <= useq_c;
			fix_s[0]  <= fix_c;
			b_s[0]    <= b_r;
			rem_s[0]  <= n_c[NW-1:17];
			nlo_s[0]  <= n_c[16:0];
			q_s[0]    <= '0;
			for (int k = 1; k <= DS; k++) begin
				last_s[k] <= last_s[k-1];
				useq_s[k] <= useq_s[k-1];
				fix_s[k]  <= fix_s[k-1];
				b_s[k]    <= b_s[k-1];
				rem_s[k]  <= ge_c[k] ? AW'(t_c[k] - {1'b0, b_s[k-1]}) : t_c[k][AW-1:0];
				nlo_s[k]  <= nlo_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][15:0], ge_c[k]};
			end
			pix_q  <= useq_s[DS] ? q_s[DS] : fix_s[DS];
			last_q <= last_s[DS];
		end
	end
endmodule

/* rtl/core/asinh_stretch_mono_pixel.sv */
// Monochrome asinh stretch: each pixel (unsigned Q1.16) is black-point shifted,
// p = max(0, (x - black_point) / (1 - black_point)), then mapped to
// asinh(beta*p)/asinh(beta) in unsigned Q1.16, clamped to [0,1]; beta = 0 passes p.
// Fully pipelined: one pixel per clock while m_tready does not stall the output. The
// pipeline depth is set by the bit-per-stage divides, the square root and
// the FRAC_BITS squaring stages of each log unit. A short queue sits between
// the divide front end and the asinh back end; m_tready low stalls only the
// back end until the queue fills. Write the registers only while no pixel is
// in flight.
module asinh_stretch_mono_pixel #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [16:0] pixel_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [16:0] pixel_out
	output logic        m_tlast
);
	localparam int YW = FRAC_BITS + 16;
	localparam int QW = 2 * YW + 16 + 1 + 2;

	logic [23:0] beta_q;
	logic [15:0] off_q;

	logic          f_valid, q_full, q_nonempty, q_pop;
	logic [YW-1:0] f_ya, f_yb, b_ya, b_yb;
	logic [15:0]   f_p, b_p;
	logic          f_last, b_last;
	asp_pkg::cls_t f_cls, b_cls;
	logic [QW-1:0] q_rdata;
	logic [16:0]   pix_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= 24'd256;
			off_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == asp_pkg::REG_STRENGTH)
				beta_q <= cfg_data;
			if (cfg_idx == asp_pkg::REG_BLACK)
				off_q <= cfg_data[15:0];
		end
	end

	asp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.beta(beta_q), .offset(off_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.pixel(s_tdata[16:0]), .last(s_tlast),
		.out_valid(f_valid), .out_full(q_full),
		.y_a(f_ya), .y_b(f_yb), .p(f_p), .out_last(f_last), .out_cls(f_cls)
	);

	asp_fifo #(.W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid), .wdata({f_cls, f_last, f_p, f_yb, f_ya}), .full(q_full),
		.pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
	);

	assign b_ya   = q_rdata[YW-1:0];
	assign b_yb   = q_rdata[2*YW-1:YW];
	assign b_p    = q_rdata[2*YW+15:2*YW];
	assign b_last = q_rdata[2*YW+16];
	assign b_cls  = asp_pkg::cls_t'(q_rdata[QW-1:QW-2]);

	asp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_nonempty), .pop(q_pop),
		.y_a(b_ya), .y_b(b_yb), .p(b_p), .last(b_last), .cls(b_cls),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.pixel(pix_out), .out_last(m_tlast)
	);

	assign m_tdata = {7'b0, pix_out};
endmodule

/* sim/asinh_stretch_mono_pixel_tb.sv */
`timescale 1ns / 100ps

module asinh_stretch_mono_pixel_tb;

	localparam int FB = 16;
	localparam int LAT = 3 * FB + 48;
	localparam int WDOG = 4000;

	typedef struct packed {
		logic [16:0] pix;
		logic        last;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [23:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	asinh_stretch_mono_pixel #(.FRAC_BITS(FB)) dut (.*);

	logic [23:0] beta;
	logic [15:0] offs;
	word_t       pend_q[$];
	word_t       exp_q[$];
	int          n_err;
	int          n_out;
	int          n_in;
	int          idle_cnt;
	int          s_wait;
	int          m_wait;
	bit          timed_out;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] ln_fx(logic [63:0] v);
		logic [63:0] one;
		logic [63:0] e;
		logic [63:0] m;
		logic [63:0] fr;
		logic [63:0] lg;
		one = 64'd1 << FB;
		e = 0;
		fr = 0;
		if (v < one)
			return 0;
		while ((v >> e) >= 2 * one)
			e++;
		m = v >> e;
		for (int i = FB - 1; i >= 0; i--) begin
			m = (m * m) >> FB;
			if (m >= 2 * one) begin
				m = m >> 1;
				fr = fr | (64'd1 << i);
			end
		end
		lg = (e << FB) | fr;
		return (lg * 64'd2977044472 + (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [63:0] asinh_fx(logic [63:0] y);
		logic [63:0] one;
		logic [63:0] r;
		logic [63:0] r2;
		one = 64'd1 << FB;
		if (y == 0)
			return 0;
		if (y < one)
			return ln_fx(y + isqrt64(one * one + y * y));
		r = (one * one) / y;
		r2 = (r * r) >> FB;
		return ln_fx(y) + ln_fx(one + isqrt64((one + r2) << FB));
	endfunction

	function automatic logic [16:0] stretch_pix(logic [16:0] x);
		logic [63:0] p;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] res;
		if (x <= offs)
			p = 0;
		else
			p = ((64'(x) - offs) << 16) / (64'd65536 - offs);
		if (p == 0)
			res = 0;
		else if (p >= 65536)
			res = 65536;
		else if (beta == 0)
			res = p;
		else begin
			a = asinh_fx((64'(beta) * p) >> (24 - FB));
			b = asinh_fx((64'(beta) * 64'd65536) >> (24 - FB));
			if (b == 0)
				res = p;
			else begin
				res = ((a << 16) + b / 2) / b;
				if (res > 65536)
					res = 65536;
			end
		end
		return res[16:0];
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			exp_q.push_back('{stretch_pix(s_tdata[16:0]), s_tlast});
			n_in++;
		end
		if (s_tvalid && s_tready || !s_tvalid) begin
			if (s_wait > 0 || pend_q.size() == 0) begin
				s_tvalid <= 1'b0;
				if (s_wait > 0)
					s_wait--;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, pend_q[0].pix};
				s_tlast <= pend_q[0].last;
				void'(pend_q.pop_front());
				s_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word pix=%0d last=%0b", m_tdata[16:0], m_tlast);
			end else begin
				if (m_tdata[16:0] !== exp_q[0].pix || m_tlast !== exp_q[0].last) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch beta=%0d off=%0d: exp %0d/%0b got %0d/%0b",
							beta, offs, exp_q[0].pix, exp_q[0].last,
							m_tdata[16:0], m_tlast);
				end
				void'(exp_q.pop_front());
			end
			n_out++;
			m_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		end
		if (m_wait > 0) begin
			m_tready <= 1'b0;
			m_wait--;
		end else begin
			m_tready <= 1'b1;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WDOG && !timed_out) begin
			timed_out = 1;
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == asp_pkg::REG_STRENGTH)
			beta = val;
		else
			offs = val[15:0];
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || s_tvalid || exp_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 20) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_pix();
		case ($urandom_range(0, 5))
			0: return 17'($urandom_range(0, 131071));
			1: return 17'(offs) + 17'($urandom_range(0, 64));
			2: return 17'($urandom_range(65400, 65600));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic push_pix(logic [16:0] x, logic l);
		pend_q.push_back('{x, l});
	endtask

	initial begin
		logic [23:0] betas[8];
		logic [15:0] offsets[8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = asp_pkg::REG_STRENGTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		beta = 24'd256;
		offs = 16'd0;
		n_err = 0;
		n_out = 0;
		n_in = 0;
		idle_cnt = 0;
		s_wait = 0;
		m_wait = 0;
		timed_out = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, directed extremes
		push_pix(17'd0, 1'b0);
		push_pix(17'd1, 1'b1);
		push_pix(17'd32768, 1'b0);
		push_pix(17'd65535, 1'b0);
		push_pix(17'd65536, 1'b1);
		push_pix(17'd131071, 1'b0);
		drain();
		write_reg(asp_pkg::REG_STRENGTH, 24'd0);
		push_pix(17'd12345, 1'b0);
		push_pix(17'd65535, 1'b1);
		push_pix(17'd70000, 1'b0);
		drain();
		write_reg(asp_pkg::REG_STRENGTH, 24'hFFFFFF);
		write_reg(asp_pkg::REG_BLACK, 24'h00FFFF);
		push_pix(17'd65535, 1'b0);
		push_pix(17'd65536, 1'b1);
		push_pix(17'd131071, 1'b0);
		push_pix(17'd0, 1'b0);
		drain();
		write_reg(asp_pkg::REG_STRENGTH, 24'd1);
		write_reg(asp_pkg::REG_BLACK, 24'd1000);
		push_pix(17'd1000, 1'b0);
		push_pix(17'd1001, 1'b1);
		push_pix(17'd40000, 1'b0);
		push_pix(17'd65535, 1'b0);
		drain();

		betas = '{24'd0, 24'd1, 24'd256, 24'd2560, 24'd25600, 24'hFFFFFF, 24'd3, 24'd0};
		offsets = '{16'd0, 16'hFFFF, 16'd500, 16'd32768, 16'd0, 16'd100, 16'd60000, 16'd0};
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				betas[ph] = 24'($urandom_range(0, 24'hFFFFFF));
			else if (ph >= 5)
				betas[ph] = 24'($urandom_range(1, 40000));
			if (ph == 7)
				offsets[ph] = 16'($urandom_range(0, 16'hFFFF));
			write_reg(asp_pkg::REG_STRENGTH, betas[ph]);
			write_reg(asp_pkg::REG_BLACK, 24'(offsets[ph]));
			for (int i = 0; i < 190; i++)
				push_pix(rand_pix(), $urandom_range(0, 15) == 0);
			drain();
		end

		$display("%0d pixels in, %0d out over 12 register settings", n_in, n_out);
		if (n_err == 0 && exp_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
